FILE: rtl/core/afcadpcm_pkg.sv
// ----------------------------------------------------------------------------
// afcadpcm_pkg
// Shared types, constants and arithmetic for the block ADPCM decoder:
// per-channel state record, control and status bundles, sequencer states,
// the Q11 predictor coefficient table and the saturating sample function.
// ----------------------------------------------------------------------------
package afcadpcm_pkg;

   localparam int DEFAULT_MAX_CHANNELS = 8;
   localparam logic [3:0] GROUP_DATA_BYTES = 4'd8;
   localparam logic [3:0] PHASE_HEADER = 4'd0;
   localparam logic [3:0] PHASE_FIRST_DATA = 4'd1;
   localparam int COEF_FRAC_BITS = 11;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

   // predictor taps, Q11, indexed by filter row
   localparam logic signed [13:0] COEF0 [16] = '{
      14'sd0,     14'sd2048,  14'sd0,     14'sd1024,
      14'sd4096,  14'sd3584,  14'sd3072,  14'sd4608,
      14'sd4200,  14'sd4800,  14'sd5120,  14'sd2048,
      14'sd1024,  -14'sd1024, -14'sd1024, -14'sd2048
   };
   localparam logic signed [13:0] COEF1 [16] = '{
      14'sd0,     14'sd0,     14'sd2048,  14'sd1024,
      -14'sd2048, -14'sd1536, -14'sd1024, -14'sd2560,
      -14'sd2248, -14'sd2300, -14'sd3072, -14'sd2048,
      -14'sd1024, 14'sd1024,  14'sd0,     14'sd0
   };

   // decoder state held per channel
   typedef struct packed {
      logic [3:0]        shift;
      logic [3:0]        row;
      logic signed [15:0] prev;
      logic signed [15:0] prev2;
      logic [3:0]        phase;
   } chan_state_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_SUM1,
      ST_MUL2,
      ST_SUM2
   } fsm_state_type;

   // sequencer to datapath
   typedef struct packed {
      logic capture;
      logic mul1;
      logic sum1;
      logic mul2;
      logic emit;
      logic wr_hdr;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic is_header;
      logic out_free;
   } stat_type;

   // prediction plus scaled code, floor shift, saturated to 16 bits
   function automatic logic signed [15:0] pred_sat(
      input logic signed [31:0] acc,
      input logic [3:0]         code,
      input logic [3:0]         shift
   );
      logic signed [20:0] pred;
      logic signed [19:0] term;
      logic signed [21:0] total;
      pred  = 21'(acc >>> COEF_FRAC_BITS);
      term  = {{16{code[3]}}, code};
      term  = term <<< shift;
      total = 22'(pred) + 22'(term);
      if (total > 22'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end else if (total < 22'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return total[15:0];
   endfunction

endpackage

FILE: rtl/core/afc_adpcm_block_decoder_top.sv
// ----------------------------------------------------------------------------
// afc_adpcm_block_decoder_top
// Multi-channel 4-bit ADPCM decoder: one tagged stream byte per item, two
// saturated 16-bit samples per data byte, nine-byte groups per channel.
// ----------------------------------------------------------------------------
// Each channel's state (shift, filter row, two history samples, group
// position) lives in one state memory with a registered read.
// The block takes one item at a time: a header byte passes through accept,
// state read and write-back, and a data byte through accept, state read,
// two multiply and sum-saturate passes (the second depending on the first
// sample), then write-back. The result register lets
// the next item be taken while a result still waits; the block holds only
// when a second result is ready and the first has not been taken. Items
// for a channel at or above MAX_CHANNELS are taken and dropped. After reset
// all channels start at zero state, expecting a header, with no clearing
// pass.
// ----------------------------------------------------------------------------
module afc_adpcm_block_decoder_top
   import afcadpcm_pkg::*;
#(
   parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_channel,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_channel,
   output logic signed [15:0] rsp_sample_first,
   output logic signed [15:0] rsp_sample_second
);

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   ctrl_type         ctl;
   stat_type         stat;
   chan_state_type   rd_state;
   chan_state_type   wr_state;
   logic             rd_en;
   logic             wr_en;
   logic             chan_ok;
   logic [2:0]       chan;
   logic [IDX_W+2:0] rd_wide;
   logic [IDX_W+2:0] wr_wide;

   // channel number to memory index
   assign chan_ok = ({29'd0, req_channel} < 32'(MAX_CHANNELS));
   assign rd_wide = {IDX_W'(0), req_channel};
   assign wr_wide = {IDX_W'(0), chan};

   afcadpcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .chan_ok   (chan_ok),
      .stat      (stat),
      .ctl       (ctl),
      .rd_en     (rd_en),
      .wr_en     (wr_en)
   );

   afcadpcm_state_mem #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .IDX_W        (IDX_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_wide[IDX_W-1:0]),
      .rd_data (rd_state),
      .wr_en   (wr_en),
      .wr_addr (wr_wide[IDX_W-1:0]),
      .wr_data (wr_state)
   );

   afcadpcm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .stat              (stat),
      .req_channel       (req_channel),
      .req_data_byte     (req_data_byte),
      .rd_state          (rd_state),
      .wr_state          (wr_state),
      .chan              (chan),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_sample_first  (rsp_sample_first),
      .rsp_sample_second (rsp_sample_second)
   );

endmodule

FILE: rtl/core/afcadpcm_state_mem.sv
// ----------------------------------------------------------------------------
// afcadpcm_state_mem
// Per-channel decoder state memory: one write port, one registered read
// port, and a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module afcadpcm_state_mem
   import afcadpcm_pkg::*;
#(
   parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS,
   parameter int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output chan_state_type   rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  chan_state_type   wr_data
);

   chan_state_type          mem [MAX_CHANNELS];
   chan_state_type          rd_data_ff;
   logic                    rd_valid_ff;
   logic [MAX_CHANNELS-1:0] valid_ff;

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // written marks, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as the reset state
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/afcadpcm_datapath.sv
// ----------------------------------------------------------------------------
// afcadpcm_datapath
// Item capture, the two-pass predictor (multiply stage, then sum and
// saturate), state update for write-back and the result register.
// ----------------------------------------------------------------------------
module afcadpcm_datapath
   import afcadpcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctl,
   output stat_type            stat,
   input  logic [2:0]          req_channel,
   input  logic [7:0]          req_data_byte,
   input  chan_state_type      rd_state,
   output chan_state_type      wr_state,
   output logic [2:0]          chan,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [2:0]          rsp_out_channel,
   output logic signed [15:0]  rsp_sample_first,
   output logic signed [15:0]  rsp_sample_second
);

   logic [2:0]         chan_ff;
   logic [7:0]         byte_ff;
   logic signed [29:0] p0_ff;
   logic signed [29:0] p1_ff;
   logic signed [29:0] q1_ff;
   logic signed [29:0] p2_ff;
   logic signed [15:0] s1_ff;
   logic signed [15:0] s2;
   logic signed [13:0] c0;
   logic signed [13:0] c1;
   logic [3:0]         phase_next;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_chan_ff;
   logic signed [15:0] rsp_s1_ff;
   logic signed [15:0] rsp_s2_ff;

   // coefficients of the channel's current filter row
   assign c0 = COEF0[rd_state.row];
   assign c1 = COEF1[rd_state.row];

   // hold the item for the whole decode
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         chan_ff <= req_channel;
         byte_ff <= req_data_byte;
      end
   end

   // multiply stages: both taps for the first sample, the older tap of the
   // second sample in parallel, then the newer tap once the first is known
   always_ff @(posedge clock) begin
      if (ctl.mul1) begin
         p0_ff <= 30'(rd_state.prev) * 30'(c0);
         p1_ff <= 30'(rd_state.prev2) * 30'(c1);
         q1_ff <= 30'(rd_state.prev) * 30'(c1);
      end
      if (ctl.sum1) begin
         s1_ff <= pred_sat(32'(p0_ff) + 32'(p1_ff), byte_ff[7:4], rd_state.shift);
      end
      if (ctl.mul2) begin
         p2_ff <= 30'(s1_ff) * 30'(c0);
      end
   end

   // second sample, finished in the cycle it is written back
   assign s2 = pred_sat(32'(p2_ff) + 32'(q1_ff), byte_ff[3:0], rd_state.shift);

   // group position after a data byte
   assign phase_next = (rd_state.phase >= GROUP_DATA_BYTES) ? PHASE_HEADER
                                                           : rd_state.phase + 4'd1;

   // new channel state for write-back
   always_comb begin
      wr_state = rd_state;
      if (ctl.wr_hdr) begin
         wr_state.shift = byte_ff[7:4];
         wr_state.row   = byte_ff[3:0];
         wr_state.phase = PHASE_FIRST_DATA;
      end else begin
         wr_state.prev  = s2;
         wr_state.prev2 = s1_ff;
         wr_state.phase = phase_next;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_chan_ff <= chan_ff;
         rsp_s1_ff   <= s1_ff;
         rsp_s2_ff   <= s2;
      end
   end

   // status back to the sequencer
   assign stat.is_header = (rd_state.phase == PHASE_HEADER) ||
                           (rd_state.phase > GROUP_DATA_BYTES);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign chan              = chan_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_chan_ff;
   assign rsp_sample_first  = rsp_s1_ff;
   assign rsp_sample_second = rsp_s2_ff;

endmodule

FILE: rtl/core/afcadpcm_ctrl.sv
// ----------------------------------------------------------------------------
// afcadpcm_ctrl
// Sequencer: accepts one item, reads the channel state, runs the two
// predictor passes for a data byte and writes the state back.
// ----------------------------------------------------------------------------
module afcadpcm_ctrl
   import afcadpcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     chan_ok,
   input  stat_type stat,
   output ctrl_type ctl,
   output logic     rd_en,
   output logic     wr_en
);

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && chan_ok) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = stat.is_header ? ST_IDLE : ST_MUL1;
         end
         ST_MUL1: state_in = ST_SUM1;
         ST_SUM1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM2;
         ST_SUM2: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      ctl.capture = (state_ff == ST_IDLE) && req_valid;
      ctl.mul1    = (state_ff == ST_MUL1);
      ctl.sum1    = (state_ff == ST_SUM1);
      ctl.mul2    = (state_ff == ST_MUL2);
      ctl.emit    = (state_ff == ST_SUM2) && stat.out_free;
      ctl.wr_hdr  = (state_ff == ST_READ) && stat.is_header;
      rd_en       = accept && chan_ok;
      wr_en       = ctl.wr_hdr || ctl.emit;
   end

endmodule
